### design/ise_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_pkg
// Shared constants and types of the insertion sort engine.
// ----------------------------------------------------------------------------
package ise_pkg;

	localparam int CAPACITY = 64;
	localparam int VAL_W    = 32;

	typedef logic signed [VAL_W-1:0] val_t;

	// command applied to every cell in the same cycle
	typedef struct packed {
		logic ins;
		logic shift;
	} ise_cmd_t;

	// what a cell shows to its neighbors
	typedef struct packed {
		val_t val;
		logic occ;
		logic gt;
	} ise_link_t;

endpackage
`default_nettype wire

### design/ise_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_in_if
// Input item channel: value to sort and last-of-set mark.
// ----------------------------------------------------------------------------
interface ise_in_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        value;
	logic                      is_final;

	modport source (output valid, output value, output is_final, input ready);
	modport sink   (input valid, input value, input is_final, output ready);
endinterface
`default_nettype wire

### design/ise_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_out_if
// Result channel: sorted value with end and overflow marks.
// ----------------------------------------------------------------------------
interface ise_out_if;
	logic                      valid;
	logic                      ready;
	logic signed [31:0]        sorted_value;
	logic                      end_of_run;
	logic                      overflowed;

	modport source (output valid, output sorted_value, output end_of_run,
		output overflowed, input ready);
	modport sink   (input valid, input sorted_value, input end_of_run,
		input overflowed, output ready);
endinterface
`default_nettype wire

### design/insertion_sort_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// insertion_sort_engine
// Stable ascending sort of signed 32-bit values in a chain of cells.
// ----------------------------------------------------------------------------
// Values arrive one per transfer on items and are inserted into a chain
// of CAPACITY cells kept in ascending order: every cell compares its
// entry with the new value, cells holding a strictly greater entry take
// their left neighbor's entry, and the first such cell (or the first empty
// one) takes the new value, so equal values stay in arrival order. While
// collecting, one value is taken per cycle. A transfer marked is_final
// inserts its value and then the chain drains from cell 0, one result per
// cycle on results while results is ready, the whole chain shifting down
// on each transfer; items is held off until every stored value has drained.
// end_of_run marks the largest value. Values arriving with the chain full are
// dropped and every result of that set carries overflowed. After the last
// result the chain is empty and ready for the next set.
module insertion_sort_engine (
	input  wire logic clk,
	input  wire logic arst_n,
	ise_in_if.sink    items,
	ise_out_if.source results
);
	import ise_pkg::*;

	ise_cmd_t  cmd;
	ise_link_t link [CAPACITY];
	ise_link_t left_of [CAPACITY];
	ise_link_t right_of [CAPACITY];

	logic drain_q;   // draining the chain to the result port
	logic ovf_q;     // a value of this set was dropped
	logic in_xfer;
	logic out_xfer;
	logic full;
	logic last_out;

	assign full     = link[CAPACITY-1].occ;
	assign in_xfer  = items.valid && items.ready;
	assign out_xfer = results.valid && results.ready;
	// cell 1 empty means cell 0 holds the largest value left
	assign last_out = !link[1].occ;

	// no insert while full: the value is dropped
	assign cmd.ins   = in_xfer && !full;
	assign cmd.shift = out_xfer;

	assign items.ready = !drain_q;

	assign results.valid        = drain_q;
	assign results.sorted_value = link[0].val;
	assign results.end_of_run   = last_out;
	assign results.overflowed   = ovf_q;

	// chain wiring: cell 0 sees an occupied, never-greater left edge,
	// the last cell sees an empty right edge
	for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
		if (i == 0) begin : g_first
			assign left_of[i] = '{val: '0, occ: 1'b1, gt: 1'b0};
		end else begin : g_mid_l
			assign left_of[i] = link[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_of[i] = '{val: '0, occ: 1'b0, gt: 1'b0};
		end else begin : g_mid_r
			assign right_of[i] = link[i+1];
		end

		ise_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.new_val (items.value),
			.left    (left_of[i]),
			.right   (right_of[i]),
			.own     (link[i])
		);
	end

	// set / drain control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (in_xfer && items.is_final) begin
				drain_q <= 1'b1;
			end else if (out_xfer && last_out) begin
				drain_q <= 1'b0;
			end
			// dropped value sets the flag, the final result clears it
			if (in_xfer && full) begin
				ovf_q <= 1'b1;
			end else if (out_xfer && last_out) begin
				ovf_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### design/ise_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_cell
// One slot of the sorted chain: holds a value and an occupied bit.
// ----------------------------------------------------------------------------
module ise_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ise_pkg::ise_cmd_t cmd,
	input  wire ise_pkg::val_t     new_val,
	input  wire ise_pkg::ise_link_t left,
	input  wire ise_pkg::ise_link_t right,
	output ise_pkg::ise_link_t     own
);
	import ise_pkg::*;

	val_t val_q;
	logic occ_q;
	logic gt;
	logic take_new;

	// strictly greater keeps equal values in arrival order
	assign gt       = occ_q && (val_q > new_val);
	assign take_new = gt || (!occ_q && left.occ);

	assign own.val = val_q;
	assign own.occ = occ_q;
	assign own.gt  = gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (cmd.shift) begin
			occ_q <= right.occ;
		end else if (cmd.ins) begin
			occ_q <= occ_q || left.occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= right.val;
		end else if (cmd.ins) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (take_new) begin
				val_q <= new_val;
			end
		end
	end

endmodule
`default_nettype wire

### design/ise_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ise_checker
// Port-level checks of the insertion sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module ise_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic in_is_final,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_end_of_run,
	input wire logic out_overflowed
);

	// input is held off for the whole drain
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while results pending");

	// a final transfer always starts a drain
	a_final_drain: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_is_final |=> out_valid)
		else $error("no results after final transfer");

	// the end-marked transfer closes the set
	a_end_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_end_of_run |=> !out_valid && in_ready)
		else $error("drain continues past end of run");

	// overflow flag is the same on every result of a set
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> $stable(out_overflowed))
		else $error("overflow flag changed within a set");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (items.valid),
	.in_ready       (items.ready),
	.in_is_final    (items.is_final),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.out_end_of_run (results.end_of_run),
	.out_overflowed (results.overflowed)
);
`default_nettype wire
